@@ sv/assert_macros.svh @@
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// implication: when cond holds, expr holds in the next cycle
`define ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rstn, expr, msg)
`define ASSERT_NEXT(label, clk, rstn, cond, expr, msg)

`endif

`endif

@@ sv/lss_pkg.sv @@
`timescale 1ns / 1ps

package lss_pkg;

    typedef logic signed [31:0] word_t;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_ERASE  = 2'd2,
        REQ_SEARCH = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_WALK,
        FSM_FINISH
    } fsm_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        logic     keep;
        word_t    word;
    } cell_ctrl_t;

endpackage

@@ sv/lss_cell.sv @@
`timescale 1ns / 1ps

module lss_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic               aclk,
    input  lss_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]   fill,
    input  lss_pkg::word_t     above_data,
    input  lss_pkg::word_t     below_data,
    output lss_pkg::word_t     data
);

    // one-based position, compared against the live region size
    localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX + 1);

    lss_pkg::word_t data_reg;
    lss_pkg::word_t data_next;

    always_comb begin
        data_next = data_reg;
        unique case (ctrl.op)
            lss_pkg::CELL_HOLD: begin
                data_next = data_reg;
            end
            lss_pkg::CELL_PUSH: begin
                data_next = (INDEX == 0) ? ctrl.word : above_data;
            end
            lss_pkg::CELL_POP: begin
                data_next = below_data;
            end
            lss_pkg::CELL_ROTATE: begin
                // region moves up by one, old top re-enters at the bottom of the region when keep is set
                if (POS < fill) begin
                    data_next = below_data;
                end else if (POS == fill && ctrl.keep) begin
                    data_next = ctrl.word;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ sv/lifo_stack_with_search_erase_top.sv @@
// push and pop: the cells update on the input transfer; FINISH then loads the output register
// erase and search: WALK rotates the entries through the cell chain once, one per cycle past
//   the top cell, and FINISH then loads the output register; inputs are taken only in IDLE
// FINISH waits while an unread result is held; a result may wait in the output register while the next input is taken
// aresetn (synchronous, active low) empties the stack and clears the result channel
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lifo_stack_with_search_erase_top #(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic signed [31:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic                m_found,
    output logic signed [31:0]  m_top_value,
    output logic                m_top_valid,
    output logic [4:0]          m_fill_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lss_pkg::fsm_t      state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [CNT_W-1:0]   steps_reg, steps_next;
    lss_pkg::req_t      req_reg, req_next;
    lss_pkg::word_t     value_reg, value_next;
    lss_pkg::status_t   status_reg, status_next;
    logic               found_reg, found_next;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic               m_found_reg, m_found_next;
    lss_pkg::word_t     m_top_value_reg, m_top_value_next;
    logic               m_top_valid_reg, m_top_valid_next;
    logic [CNT_W-1:0]   m_count_reg, m_count_next;

    lss_pkg::cell_ctrl_t ctrl;
    lss_pkg::word_t      cell_data [DEPTH];
    lss_pkg::word_t      top_word;
    logic                hit;
    logic [CNT_W+4:0]    fill_wide;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            lss_pkg::word_t above_w;
            lss_pkg::word_t below_w;
            if (g == 0) begin : g_first
                assign above_w = ctrl.word;
            end else begin : g_mid_a
                assign above_w = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign below_w = cell_data[g];
            end else begin : g_mid_b
                assign below_w = cell_data[g+1];
            end
            lss_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .fill       (live_reg),
                .above_data (above_w),
                .below_data (below_w),
                .data       (cell_data[g])
            );
        end
    endgenerate

    assign top_word = cell_data[0];
    assign hit      = (top_word == value_reg);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        live_next        = live_reg;
        steps_next       = steps_reg;
        req_next         = req_reg;
        value_next       = value_reg;
        status_next      = status_reg;
        found_next       = found_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_found_next     = m_found_reg;
        m_top_value_next = m_top_value_reg;
        m_top_valid_next = m_top_valid_reg;
        m_count_next     = m_count_reg;
        ctrl.op          = lss_pkg::CELL_HOLD;
        ctrl.keep        = 1'b0;
        ctrl.word        = s_value;
        s_ready          = 1'b0;

        unique case (state_reg)
            lss_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next    = lss_pkg::req_t'(s_req_type);
                    value_next  = s_value;
                    status_next = lss_pkg::STAT_OK;
                    found_next  = 1'b0;
                    live_next   = count_reg;
                    steps_next  = count_reg;
                    unique case (lss_pkg::req_t'(s_req_type))
                        lss_pkg::REQ_PUSH: begin
                            if (count_reg == FULL_CNT) begin
                                status_next = lss_pkg::STAT_FULL;
                            end else begin
                                ctrl.op    = lss_pkg::CELL_PUSH;
                                count_next = count_reg + 1'b1;
                            end
                            state_next = lss_pkg::FSM_FINISH;
                        end
                        lss_pkg::REQ_POP: begin
                            if (count_reg == '0) begin
                                status_next = lss_pkg::STAT_EMPTY;
                            end else begin
                                ctrl.op    = lss_pkg::CELL_POP;
                                count_next = count_reg - 1'b1;
                            end
                            state_next = lss_pkg::FSM_FINISH;
                        end
                        lss_pkg::REQ_ERASE,
                        lss_pkg::REQ_SEARCH: begin
                            state_next = lss_pkg::FSM_WALK;
                        end
                        default: state_next = lss_pkg::FSM_FINISH;
                    endcase
                end
            end
            lss_pkg::FSM_WALK: begin
                if (steps_reg == '0) begin
                    count_next = live_reg;
                    state_next = lss_pkg::FSM_FINISH;
                end else begin
                    ctrl.op    = lss_pkg::CELL_ROTATE;
                    ctrl.word  = top_word;
                    ctrl.keep  = !(req_reg == lss_pkg::REQ_ERASE && hit);
                    steps_next = steps_reg - 1'b1;
                    if (req_reg == lss_pkg::REQ_SEARCH && hit) begin
                        found_next = 1'b1;
                    end
                    if (!ctrl.keep) begin
                        live_next = live_reg - 1'b1;
                    end
                end
            end
            lss_pkg::FSM_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = status_reg;
                    m_found_next     = found_reg;
                    m_top_valid_next = (count_reg != '0);
                    m_top_value_next = (count_reg != '0) ? top_word : '0;
                    m_count_next     = count_reg;
                    state_next       = lss_pkg::FSM_IDLE;
                end
            end
            default: state_next = lss_pkg::FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lss_pkg::FSM_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        live_reg        <= live_next;
        steps_reg       <= steps_next;
        req_reg         <= req_next;
        value_reg       <= value_next;
        status_reg      <= status_next;
        found_reg       <= found_next;
        m_status_reg    <= m_status_next;
        m_found_reg     <= m_found_next;
        m_top_value_reg <= m_top_value_next;
        m_top_valid_reg <= m_top_valid_next;
        m_count_reg     <= m_count_next;
    end

    // fill count reported modulo 32
    assign fill_wide    = {5'b0, m_count_reg};
    assign m_fill_count = fill_wide[4:0];
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found      = m_found_reg;
    assign m_top_value  = m_top_value_reg;
    assign m_top_valid  = m_top_valid_reg;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= FULL_CNT,
        "fill count above depth")
    `ASSERT_ALWAYS(a_walk_steps, aclk, aresetn,
        (state_reg != lss_pkg::FSM_WALK) || (steps_reg <= live_reg),
        "walk steps exceed live region")
    `ASSERT_NEXT(a_push_grows, aclk, aresetn,
        s_valid && s_ready && s_req_type == lss_pkg::REQ_PUSH && count_reg != FULL_CNT,
        count_reg == $past(count_reg) + 1'b1, "push did not grow the stack")
    `ASSERT_NEXT(a_pop_empty, aclk, aresetn,
        s_valid && s_ready && s_req_type == lss_pkg::REQ_POP && count_reg == '0,
        count_reg == '0 && status_reg == lss_pkg::STAT_EMPTY, "pop on empty mishandled")

endmodule

@@ bench/tb_lifo_stack_with_search_erase_top.sv @@
`timescale 1ns / 1ps

module tb_lifo_stack_with_search_erase_top;

    localparam int STACK_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 1330;
    localparam int TAIL_ITEMS    = 150;
    localparam int DIRECTED_ROWS = 25;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;

    localparam lss_pkg::word_t WORD_MIN = 32'sh8000_0000;
    localparam lss_pkg::word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam lss_pkg::word_t COMMON_WORDS [8] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd7, 32'sd42, WORD_MIN, WORD_MAX, 32'sh5A5A_A5A5
    };

    typedef struct packed {
        lss_pkg::status_t status;
        logic             found;
        lss_pkg::word_t   top_value;
        logic             top_valid;
        logic [4:0]       fill_count;
    } result_t;

    typedef struct packed {
        lss_pkg::req_t  req;
        lss_pkg::word_t word;
        logic           pinned;
        result_t        want;
    } step_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type = lss_pkg::REQ_PUSH;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic               m_found;
    logic signed [31:0] m_top_value;
    logic               m_top_valid;
    logic [4:0]         m_fill_count;

    // typed expectation that rides along with the item being offered
    logic    pin_on = 1'b0;
    result_t pin_want = '0;

    lss_pkg::word_t shadow_mem [STACK_DEPTH];
    int      shadow_fill = 0;
    result_t pending_results [$];
    int      accepted_items = 0;
    int      bad_results = 0;
    int      reported = 0;
    bit      tail_phase = 1'b0;
    bit      long_hold_done = 1'b0;

    lifo_stack_with_search_erase_top #(
        .DEPTH(STACK_DEPTH)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_found     (m_found),
        .m_top_value (m_top_value),
        .m_top_valid (m_top_valid),
        .m_fill_count(m_fill_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic result_t next_stack_result(lss_pkg::req_t req, lss_pkg::word_t w);
        result_t r;
        int      kept;
        r = '0;
        r.status = lss_pkg::STAT_OK;
        case (req)
            lss_pkg::REQ_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    r.status = lss_pkg::STAT_FULL;
                end else begin
                    shadow_mem[shadow_fill] = w;
                    shadow_fill++;
                end
            end
            lss_pkg::REQ_POP: begin
                if (shadow_fill == 0) begin
                    r.status = lss_pkg::STAT_EMPTY;
                end else begin
                    shadow_fill--;
                end
            end
            lss_pkg::REQ_ERASE: begin
                // survivors close up toward the bottom in their old order
                kept = 0;
                for (int i = 0; i < shadow_fill; i++) begin
                    if (shadow_mem[i] != w) begin
                        shadow_mem[kept] = shadow_mem[i];
                        kept++;
                    end
                end
                shadow_fill = kept;
            end
            default: begin
                for (int i = 0; i < shadow_fill; i++) begin
                    if (shadow_mem[i] == w) begin
                        r.found = 1'b1;
                    end
                end
            end
        endcase
        if (shadow_fill > 0) begin
            r.top_value = shadow_mem[shadow_fill - 1];
            r.top_valid = 1'b1;
        end
        r.fill_count = 5'(shadow_fill);
        return r;
    endfunction

    function automatic step_t fixed_step(lss_pkg::req_t req, lss_pkg::word_t w,
                                         lss_pkg::status_t st, logic found,
                                         lss_pkg::word_t top, logic top_valid,
                                         logic [4:0] fill);
        step_t s;
        s.req = req;
        s.word = w;
        s.pinned = 1'b1;
        s.want.status = st;
        s.want.found = found;
        s.want.top_value = top;
        s.want.top_valid = top_valid;
        s.want.fill_count = fill;
        return s;
    endfunction

    function automatic step_t predicted_step(lss_pkg::req_t req, lss_pkg::word_t w);
        step_t s;
        s = '0;
        s.req = req;
        s.word = w;
        return s;
    endfunction

    task automatic send_request(lss_pkg::req_t req, lss_pkg::word_t w, logic pinned,
                                result_t want);
        s_valid <= 1'b1;
        s_req_type <= req;
        s_value <= w;
        pin_on <= pinned;
        pin_want <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin : request_source
        step_t          script [DIRECTED_ROWS];
        result_t        no_pin;
        lss_pkg::req_t  req;
        lss_pkg::word_t w;
        int      mode;
        int      gap_odds;
        int      pick;
        int      push_cut;
        int      pop_cut;
        int      erase_cut;
        no_pin = '0;
        script = '{
            fixed_step(lss_pkg::REQ_POP, 32'sd0, lss_pkg::STAT_EMPTY, 1'b0, 32'sd0, 1'b0, 5'd0),
            fixed_step(lss_pkg::REQ_SEARCH, 32'sd0, lss_pkg::STAT_OK, 1'b0, 32'sd0, 1'b0, 5'd0),
            fixed_step(lss_pkg::REQ_ERASE, 32'sd0, lss_pkg::STAT_OK, 1'b0, 32'sd0, 1'b0, 5'd0),
            fixed_step(lss_pkg::REQ_PUSH, WORD_MIN, lss_pkg::STAT_OK, 1'b0, WORD_MIN, 1'b1,
                       5'd1),
            fixed_step(lss_pkg::REQ_PUSH, WORD_MAX, lss_pkg::STAT_OK, 1'b0, WORD_MAX, 1'b1,
                       5'd2),
            fixed_step(lss_pkg::REQ_SEARCH, WORD_MIN, lss_pkg::STAT_OK, 1'b1, WORD_MAX, 1'b1,
                       5'd2),
            predicted_step(lss_pkg::REQ_PUSH, 32'sd7),
            predicted_step(lss_pkg::REQ_PUSH, -32'sd1),
            predicted_step(lss_pkg::REQ_PUSH, 32'sd7),
            predicted_step(lss_pkg::REQ_PUSH, 32'sd0),
            predicted_step(lss_pkg::REQ_PUSH, 32'sd7),
            predicted_step(lss_pkg::REQ_PUSH, 32'sd1),
            predicted_step(lss_pkg::REQ_PUSH, 32'sd7),
            predicted_step(lss_pkg::REQ_PUSH, 32'sh5555_5555),
            predicted_step(lss_pkg::REQ_PUSH, 32'sd7),
            predicted_step(lss_pkg::REQ_PUSH, 32'shAAAA_AAAA),
            predicted_step(lss_pkg::REQ_PUSH, 32'sd7),
            predicted_step(lss_pkg::REQ_PUSH, -32'sd2),
            predicted_step(lss_pkg::REQ_PUSH, 32'sd7),
            predicted_step(lss_pkg::REQ_PUSH, 32'sd7),
            fixed_step(lss_pkg::REQ_PUSH, 32'sd3, lss_pkg::STAT_FULL, 1'b0, 32'sd7, 1'b1,
                       5'd16),
            predicted_step(lss_pkg::REQ_SEARCH, WORD_MAX),
            predicted_step(lss_pkg::REQ_ERASE, 32'sd7),
            predicted_step(lss_pkg::REQ_SEARCH, 32'sd7),
            predicted_step(lss_pkg::REQ_ERASE, WORD_MIN)
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            send_request(script[i].req, script[i].word, script[i].pinned, script[i].want);
        end

        mode = 0;
        gap_odds = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                mode = $urandom_range(0, 3);
                gap_odds = $urandom_range(0, 2) * 3;
            end
            tail_phase = (n >= RANDOM_ITEMS - TAIL_ITEMS);

            // fill, drain, mixed and scan-heavy phases walk the stack between empty and full
            case (mode)
                0:       begin push_cut = 65; pop_cut = 75; erase_cut = 85; end
                1:       begin push_cut = 15; pop_cut = 75; erase_cut = 85; end
                2:       begin push_cut = 35; pop_cut = 65; erase_cut = 80; end
                default: begin push_cut = 30; pop_cut = 50; erase_cut = 75; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < push_cut) begin
                req = lss_pkg::REQ_PUSH;
            end else if (pick < pop_cut) begin
                req = lss_pkg::REQ_POP;
            end else if (pick < erase_cut) begin
                req = lss_pkg::REQ_ERASE;
            end else begin
                req = lss_pkg::REQ_SEARCH;
            end

            // repeated words make erase and search hit; half aim at a word already held
            if (req != lss_pkg::REQ_PUSH && req != lss_pkg::REQ_POP && shadow_fill > 0
                    && $urandom_range(0, 1) == 0) begin
                w = shadow_mem[$urandom_range(0, shadow_fill - 1)];
            end else if ($urandom_range(0, 1) == 0) begin
                w = COMMON_WORDS[$urandom_range(0, 7)];
            end else begin
                w = $urandom;
            end

            if (!tail_phase && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            send_request(req, w, 1'b0, no_pin);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (bad_results == 0) begin
            $display("lifo_stack_with_search_erase_top verification clean");
        end else begin
            $display("lifo_stack_with_search_erase_top verification failed");
        end
        $finish;
    end

    initial begin : result_sink
        int hold;
        @(posedge aclk iff aresetn);
        forever begin
            if (!long_hold_done && accepted_items >= 400) begin
                // long back-pressure so the output register stays full and the block drops s_ready
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                hold = 150;
            end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                hold = $urandom_range(1, 10);
            end else begin
                m_ready <= 1'b1;
                hold = tail_phase ? 1 : $urandom_range(1, 16);
            end
            repeat (hold) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.status = lss_pkg::status_t'(m_status);
                got.found = m_found;
                got.top_value = m_top_value;
                got.top_valid = m_top_valid;
                got.fill_count = m_fill_count;
                if (pending_results.size() == 0) begin
                    bad_results++;
                    if (reported < 10) begin
                        reported++;
                        $display("unexpected result: st=%0d fnd=%0b top=%0d vld=%0b fill=%0d",
                                 got.status, got.found, got.top_value, got.top_valid,
                                 got.fill_count);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.found !== want.found
                            || got.top_value !== want.top_value
                            || got.top_valid !== want.top_valid
                            || got.fill_count !== want.fill_count) begin
                        bad_results++;
                        if (reported < 10) begin
                            reported++;
                            $display("mismatch: want st=%0d fnd=%0b top=%0d vld=%0b fill=%0d",
                                     want.status, want.found, want.top_value,
                                     want.top_valid, want.fill_count);
                            $display("          got  st=%0d fnd=%0b top=%0d vld=%0b fill=%0d",
                                     got.status, got.found, got.top_value,
                                     got.top_valid, got.fill_count);
                        end
                    end
                end
            end
            // predict after checking: a result never belongs to the transfer of the same edge
            if (s_valid && s_ready) begin
                want = next_stack_result(lss_pkg::req_t'(s_req_type), s_value);
                if (pin_on) begin
                    want = pin_want;
                end
                pending_results.push_back(want);
                accepted_items++;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("lifo_stack_with_search_erase_top verification failed");
        $finish;
    end

endmodule
